/* rtl/core/ffra_pkg.sv */
// ----------------------------------------------------------------------------
// First-fit range allocator package
// Shared constants, payload structs, status codes and sequencer states.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int FREE_ENTRIES_DEF = 32;
    localparam int USED_ENTRIES_DEF = 32;
    localparam int ADDR_BITS_DEF    = 24;
    localparam int FIELD_BITS       = 24;

    // Request kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_ALLOC     = 3'd0;
    localparam logic [2:0] ST_NOFIT     = 3'd1;
    localparam logic [2:0] ST_FREED     = 3'd2;
    localparam logic [2:0] ST_NOEFFECT  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND  = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic                  kind;
        logic [FIELD_BITS-1:0] request_size;
        logic [FIELD_BITS-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [FIELD_BITS-1:0] block_address;
        logic [FIELD_BITS-1:0] block_bytes;
    } rsp_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_SLOT,
        S_A_UPD,
        S_SH_RD,
        S_SH_WR,
        S_U_RD,
        S_U_CHK,
        S_I_RD,
        S_I_CHK,
        S_I_DEC,
        S_UP_RD,
        S_UP_WR,
        S_U_UPD
    } state_t;

endpackage

/* rtl/core/ffra_seq.sv */
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the free and used tables one entry at a time, with one read and at most
// one write per table memory per cycle, and shifts or merges free ranges entry by entry.
// ----------------------------------------------------------------------------
module ffra_seq
    import ffra_pkg::*;
#(
    parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
    parameter int USED_ENTRIES = USED_ENTRIES_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  req_t                 req,
    input  logic                 cfg_wr,
    input  logic [ADDR_BITS-1:0] memory_size,
    output logic                 busy,
    output logic                 cfg_ready,
    output logic                 done,
    output rsp_t                 rsp
);

    localparam int AW   = ADDR_BITS;
    localparam int FIDX = $clog2(FREE_ENTRIES);
    localparam int FCW  = $clog2(FREE_ENTRIES + 1);
    localparam int UIDX = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
    localparam int UCW  = $clog2(USED_ENTRIES + 1);

    // Table memories: each word holds {first, last}.
    logic [2*AW-1:0] free_mem [FREE_ENTRIES];
    logic [2*AW-1:0] used_mem [USED_ENTRIES];

    logic            fw_en;
    logic [FIDX-1:0] fw_addr;
    logic [2*AW-1:0] fw_data;
    logic [FIDX-1:0] fr_addr;
    logic [2*AW-1:0] fr_data_reg;
    logic            uw_en;
    logic [UIDX-1:0] uw_addr;
    logic [2*AW-1:0] uw_data;
    logic [UIDX-1:0] ur_addr;
    logic [2*AW-1:0] ur_data_reg;

    state_t state_reg, state_next;
    logic [FCW-1:0] cnt_reg, cnt_next;
    logic [FCW-1:0] ptr_reg, ptr_next;
    logic [FCW-1:0] sp_reg, sp_next;
    logic [UCW-1:0] slot_reg, slot_next;
    logic [USED_ENTRIES-1:0] valid_reg, valid_next;
    logic done_reg, done_next;
    rsp_t rsp_reg, rsp_next;

    logic [AW-1:0] m_reg, m_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          is_free_reg, is_free_next;
    logic [AW-1:0] b_reg, b_next;
    logic [AW-1:0] last_reg, last_next;
    logic          exact_reg, exact_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic          whole_reg, whole_next;
    logic [AW-1:0] uf_reg, uf_next;
    logic [AW-1:0] pf_reg, pf_next;
    logic [AW-1:0] pl_reg, pl_next;
    logic [AW-1:0] cf_reg, cf_next;
    logic [AW-1:0] cl_reg, cl_next;

    logic [AW-1:0] fr_first, fr_last, ur_first, ur_last;
    logic [AW:0]   range_size;
    logic          join_left, join_right;

    assign fr_first = fr_data_reg[2*AW-1:AW];
    assign fr_last  = fr_data_reg[AW-1:0];
    assign ur_first = ur_data_reg[2*AW-1:AW];
    assign ur_last  = ur_data_reg[AW-1:0];
    assign range_size = {1'b0, fr_last} - {1'b0, fr_first} + {{AW{1'b0}}, 1'b1};
    assign join_left  = (ptr_reg != '0) &&
                        (({1'b0, pl_reg} + {{AW{1'b0}}, 1'b1}) == {1'b0, lo_reg});
    assign join_right = (ptr_reg < cnt_reg) &&
                        (({1'b0, hi_reg} + {{AW{1'b0}}, 1'b1}) == {1'b0, cf_reg});

    // Free table memory, one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (fw_en)
        begin
            free_mem[fw_addr] <= fw_data;
        end
        fr_data_reg <= free_mem[fr_addr];
    end

    // Used table memory.
    always_ff @(posedge clk)
    begin
        if (uw_en)
        begin
            used_mem[uw_addr] <= uw_data;
        end
        ur_data_reg <= used_mem[ur_addr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
            sp_reg    <= '0;
            slot_reg  <= '0;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
            sp_reg    <= sp_next;
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rsp_reg     <= rsp_next;
        m_reg       <= m_next;
        addr_reg    <= addr_next;
        is_free_reg <= is_free_next;
        b_reg       <= b_next;
        last_reg    <= last_next;
        exact_reg   <= exact_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        whole_reg   <= whole_next;
        uf_reg      <= uf_next;
        pf_reg      <= pf_next;
        pl_reg      <= pl_next;
        cf_reg      <= cf_next;
        cl_reg      <= cl_next;
    end

    // Next state and table accesses.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ptr_next     = ptr_reg;
        sp_next      = sp_reg;
        slot_next    = slot_reg;
        valid_next   = valid_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        m_next       = m_reg;
        addr_next    = addr_reg;
        is_free_next = is_free_reg;
        b_next       = b_reg;
        last_next    = last_reg;
        exact_next   = exact_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        whole_next   = whole_reg;
        uf_next      = uf_reg;
        pf_next      = pf_reg;
        pl_next      = pl_reg;
        cf_next      = cf_reg;
        cl_next      = cl_reg;
        fw_en        = 1'b0;
        fw_addr      = ptr_reg[FIDX-1:0];
        fw_data      = fr_data_reg;
        fr_addr      = ptr_reg[FIDX-1:0];
        uw_en        = 1'b0;
        uw_addr      = slot_reg[UIDX-1:0];
        uw_data      = {b_reg, b_reg + m_reg - {{(AW-1){1'b0}}, 1'b1}};
        ur_addr      = slot_reg[UIDX-1:0];

        case (state_reg)
            // Load the free table with the whole managed range.
            S_INIT:
            begin
                fw_en      = 1'b1;
                fw_addr    = '0;
                fw_data    = {{{(AW-1){1'b0}}, 1'b1}, memory_size};
                cnt_next   = (memory_size != '0) ? FCW'(1) : '0;
                valid_next = '0;
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (cfg_wr)
                begin
                    state_next = S_INIT;
                end
                else if (start)
                begin
                    m_next       = AW'(req.request_size);
                    addr_next    = AW'(req.free_address);
                    is_free_next = (req.kind == KIND_FREE);
                    ptr_next     = '0;
                    slot_next    = '0;
                    if (req.kind == KIND_FREE)
                    begin
                        state_next = S_U_RD;
                    end
                    else if ((AW'(req.request_size) == '0) || (cnt_reg == '0))
                    begin
                        rsp_next  = '{ST_NOFIT, '0, '0};
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_A_RD;
                    end
                end
            end

            // First-fit scan of the free table.
            S_A_RD:
            begin
                state_next = S_A_CHK;
            end

            S_A_CHK:
            begin
                if (range_size >= {1'b0, m_reg})
                begin
                    b_next     = fr_first;
                    last_next  = fr_last;
                    exact_next = (range_size == {1'b0, m_reg});
                    state_next = S_A_SLOT;
                end
                else if (ptr_reg + FCW'(1) >= cnt_reg)
                begin
                    rsp_next   = '{ST_NOFIT, '0, '0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next   = ptr_reg + FCW'(1);
                    state_next = S_A_RD;
                end
            end

            // Look for an unused entry in the allocated table.
            S_A_SLOT:
            begin
                if (!valid_reg[slot_reg[UIDX-1:0]])
                begin
                    state_next = S_A_UPD;
                end
                else if (slot_reg == UCW'(USED_ENTRIES - 1))
                begin
                    rsp_next   = '{ST_FULL, '0, '0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next = slot_reg + UCW'(1);
                end
            end

            S_A_UPD:
            begin
                uw_en = 1'b1;
                valid_next[slot_reg[UIDX-1:0]] = 1'b1;
                rsp_next = '{ST_ALLOC, FIELD_BITS'(b_reg), FIELD_BITS'(m_reg)};
                if (exact_reg)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    fw_en      = 1'b1;
                    fw_data    = {b_reg + m_reg, last_reg};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // Remove the free entry at ptr by moving later entries down.
            S_SH_RD:
            begin
                if (ptr_reg + FCW'(1) < cnt_reg)
                begin
                    fr_addr    = FIDX'(ptr_reg + FCW'(1));
                    state_next = S_SH_WR;
                end
                else
                begin
                    cnt_next = cnt_reg - FCW'(1);
                    if (is_free_reg)
                    begin
                        state_next = S_U_UPD;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            S_SH_WR:
            begin
                fw_en      = 1'b1;
                ptr_next   = ptr_reg + FCW'(1);
                state_next = S_SH_RD;
            end

            // Search the allocated table for the range holding the address.
            S_U_RD:
            begin
                if (valid_reg[slot_reg[UIDX-1:0]])
                begin
                    state_next = S_U_CHK;
                end
                else if (slot_reg == UCW'(USED_ENTRIES - 1))
                begin
                    rsp_next   = '{ST_NOTFOUND, '0, '0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next = slot_reg + UCW'(1);
                end
            end

            S_U_CHK:
            begin
                uf_next = ur_first;
                lo_next = addr_reg;
                hi_next = ur_last;
                if (ur_first == addr_reg)
                begin
                    whole_next = 1'b1;
                    lo_next    = ur_first;
                    ptr_next   = '0;
                    state_next = S_I_RD;
                end
                else if ((ur_first < addr_reg) && (addr_reg < ur_last))
                begin
                    whole_next = 1'b0;
                    ptr_next   = '0;
                    state_next = S_I_RD;
                end
                else if (addr_reg == ur_last)
                begin
                    rsp_next   = '{ST_NOEFFECT, '0, '0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (slot_reg == UCW'(USED_ENTRIES - 1))
                begin
                    rsp_next   = '{ST_NOTFOUND, '0, '0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next  = slot_reg + UCW'(1);
                    state_next = S_U_RD;
                end
            end

            // Find the insert position in address order.
            S_I_RD:
            begin
                if (ptr_reg < cnt_reg)
                begin
                    state_next = S_I_CHK;
                end
                else
                begin
                    state_next = S_I_DEC;
                end
            end

            S_I_CHK:
            begin
                if (fr_first <= lo_reg)
                begin
                    pf_next    = fr_first;
                    pl_next    = fr_last;
                    ptr_next   = ptr_reg + FCW'(1);
                    state_next = S_I_RD;
                end
                else
                begin
                    cf_next    = fr_first;
                    cl_next    = fr_last;
                    state_next = S_I_DEC;
                end
            end

            // Merge with neighbours, or open a new entry if the free table has room.
            S_I_DEC:
            begin
                rsp_next = '{ST_FREED, FIELD_BITS'(lo_reg),
                             FIELD_BITS'(hi_reg - lo_reg + {{(AW-1){1'b0}}, 1'b1})};
                if (join_left && join_right)
                begin
                    fw_en      = 1'b1;
                    fw_addr    = FIDX'(ptr_reg - FCW'(1));
                    fw_data    = {pf_reg, cl_reg};
                    state_next = S_SH_RD;
                end
                else if (join_left)
                begin
                    fw_en      = 1'b1;
                    fw_addr    = FIDX'(ptr_reg - FCW'(1));
                    fw_data    = {pf_reg, hi_reg};
                    state_next = S_U_UPD;
                end
                else if (join_right)
                begin
                    fw_en      = 1'b1;
                    fw_data    = {lo_reg, cl_reg};
                    state_next = S_U_UPD;
                end
                else if (cnt_reg == FCW'(FREE_ENTRIES))
                begin
                    rsp_next   = '{ST_FULL, '0, '0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    sp_next    = cnt_reg;
                    state_next = S_UP_RD;
                end
            end

            // Open a gap at ptr by moving entries up, then write the new range.
            S_UP_RD:
            begin
                if (sp_reg > ptr_reg)
                begin
                    fr_addr    = FIDX'(sp_reg - FCW'(1));
                    state_next = S_UP_WR;
                end
                else
                begin
                    fw_en      = 1'b1;
                    fw_data    = {lo_reg, hi_reg};
                    cnt_next   = cnt_reg + FCW'(1);
                    state_next = S_U_UPD;
                end
            end

            S_UP_WR:
            begin
                fw_en      = 1'b1;
                fw_addr    = FIDX'(sp_reg);
                sp_next    = sp_reg - FCW'(1);
                state_next = S_UP_RD;
            end

            // Release the whole allocated entry or cut off its tail.
            S_U_UPD:
            begin
                if (whole_reg)
                begin
                    valid_next[slot_reg[UIDX-1:0]] = 1'b0;
                end
                else
                begin
                    uw_en   = 1'b1;
                    uw_data = {uf_reg, addr_reg - {{(AW-1){1'b0}}, 1'b1}};
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A request offered in the same cycle takes precedence over a configuration write.
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign done      = done_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/core/first_fit_range_allocator.sv */
// Requests are served by entry-by-entry walks of the free and used tables through one
// read port each.
// Throughput: one request at a time; busy stays high until the result strobe.
// Reset: 1-cycle table load after rst_n and after every memory_size write.
// Results appear on rsp with done, which is high for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// First-fit range allocator
// Holds the memory_size register and runs the allocation sequencer.
// ----------------------------------------------------------------------------
module first_fit_range_allocator
    import ffra_pkg::*;
#(
    parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
    parameter int USED_ENTRIES = USED_ENTRIES_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  req,
    output logic                  done,
    output rsp_t                  rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [FIELD_BITS-1:0] cfg_data
);

    logic [ADDR_BITS-1:0] memory_size_reg;
    logic                 cfg_wr;

    assign cfg_wr = cfg_valid && cfg_ready;

    // Configuration register; a transfer also reloads the tables.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_size_reg <= ADDR_BITS'(32'd65536);
        end
        else if (cfg_wr)
        begin
            memory_size_reg <= ADDR_BITS'(cfg_data);
        end
    end

    ffra_seq #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .USED_ENTRIES (USED_ENTRIES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req         (req),
        .cfg_wr      (cfg_wr),
        .memory_size (memory_size_reg),
        .busy        (busy),
        .cfg_ready   (cfg_ready),
        .done        (done),
        .rsp         (rsp)
    );

endmodule

/* rtl/core/ffra_check.sv */
// ----------------------------------------------------------------------------
// Allocator port checker
// Concurrent checks on the top-level ports, bound to the allocator.
// ----------------------------------------------------------------------------
module ffra_check
    import ffra_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp,
    input logic cfg_ready
);

    // An accepted request either finishes at once or keeps the block busy.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither busy nor done");

    // A result is only shown once the block has gone idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Status codes stay within the defined set.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status <= ST_FULL))
        else $error("undefined status code");

    // Failed requests carry no range.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != ST_ALLOC) && (rsp.status != ST_FREED))
            |-> ((rsp.block_address == '0) && (rsp.block_bytes == '0)))
        else $error("range reported for a failed request");

    // Configuration transfers are only accepted while idle.
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy)
        else $error("configuration ready while busy");

endmodule

bind first_fit_range_allocator ffra_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .rsp       (rsp),
    .cfg_ready (cfg_ready)
);
